// ===== hw/rtl/gcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid cell sample averager package
// Shared widths, operation and register codes, the cell record and the
// divider request and response types.
// ----------------------------------------------------------------------------
package gcsa_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);

    localparam int COORD_W   = 16;
    localparam int SUM_W     = 24;
    localparam int SMP_W     = 16;
    localparam int STR_W     = 8;
    localparam int NID_W     = 8;
    localparam int STEP_W    = 8;
    localparam int FILT_W    = 9;
    localparam int MEAN_W    = 12;
    localparam int FRAC_W    = 4;
    localparam int OP_W      = 2;
    localparam int SEL_W     = 10;
    localparam int REG_IDX_W = 1;
    localparam int CFG_W     = 9;

    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int DIVISOR_W  = SMP_W;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_GRID_STEP      = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_NETWORK_FILTER = 1'b1;

    // Filter value that keeps every network.
    localparam logic [FILT_W-1:0] FILTER_ALL = '1;

    typedef struct packed {
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic signed [SUM_W-1:0] sum;
        logic [SMP_W-1:0]        cnt;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ===== hw/rtl/gcsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module gcsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/gcsa_div.sv =====
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle. Gives the quotient and the
// remainder and pulses done when both are ready.
// ----------------------------------------------------------------------------
module gcsa_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gcsa_pkg::div_req_t req,
    output gcsa_pkg::div_rsp_t rsp
);

    localparam int STEP_CNT_W = $clog2(gcsa_pkg::DIVIDEND_W + 1);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [STEP_CNT_W-1:0]               step_reg, step_next;
    logic [gcsa_pkg::DIVIDEND_W-1:0]     quo_reg, quo_next;
    logic [gcsa_pkg::DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [gcsa_pkg::DIVISOR_W-1:0]      dvs_reg, dvs_next;
    logic [gcsa_pkg::DIVISOR_W:0]        shifted;
    logic [gcsa_pkg::DIVISOR_W:0]        trial;

    assign shifted = {rem_reg, quo_reg[gcsa_pkg::DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            // A clear borrow bit means the divisor fits into the partial remainder.
            if (!trial[gcsa_pkg::DIVISOR_W])
            begin
                rem_next = trial[gcsa_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[gcsa_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[gcsa_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[gcsa_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_CNT_W'(1);
            if (step_reg == STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_CNT_W'(gcsa_pkg::DIVIDEND_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/grid_cell_sample_averager.sv =====
// ----------------------------------------------------------------------------
// Grid cell sample averager
// Bins signal strength samples into map cells held in one RAM, and reads back
// a cell's coordinates and its mean strength in signed fixed point.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   in        in_valid / in_ready    op, pos_x, pos_y, network_id, strength,
//                                    starts_measurement, cell_index
//   out       out_valid / out_ready  cell_x, cell_y, mean_strength,
//                                    cell_valid, cells_used, dropped
//   cfg       cfg_write              cfg_index, cfg_data
//
// One request at a time. A clear, a filtered sample, an unused code or an
// out-of-range read goes straight to S_FINISH; a new unmerged cell passes
// S_NEW and S_UPDATE (S_NEW only when the table is full), a continuation and a
// read S_FETCH and S_LOAD, then S_UPDATE or the mean division. A merging sample
// divides twice and scans one cell per cycle. No clearing pass follows reset.
// A result waits in the output register while the next request is accepted.
module grid_cell_sample_averager (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [gcsa_pkg::OP_W-1:0]            op,
    input  logic [gcsa_pkg::COORD_W-1:0]         pos_x,
    input  logic [gcsa_pkg::COORD_W-1:0]         pos_y,
    input  logic [gcsa_pkg::NID_W-1:0]           network_id,
    input  logic signed [gcsa_pkg::STR_W-1:0]    strength,
    input  logic                                 starts_measurement,
    input  logic [gcsa_pkg::SEL_W-1:0]           cell_index,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gcsa_pkg::COORD_W-1:0]         cell_x,
    output logic [gcsa_pkg::COORD_W-1:0]         cell_y,
    output logic signed [gcsa_pkg::MEAN_W-1:0]   mean_strength,
    output logic                                 cell_valid,
    output logic [gcsa_pkg::CNT_W-1:0]           cells_used,
    output logic                                 dropped,

    input  logic                                 cfg_write,
    input  logic [gcsa_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [gcsa_pkg::CFG_W-1:0]           cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_QX,
        S_QX_WAIT,
        S_QY,
        S_QY_WAIT,
        S_SEARCH,
        S_NEW,
        S_FETCH,
        S_LOAD,
        S_UPDATE,
        S_MDIV,
        S_MDIV_WAIT,
        S_FINISH
    } state_t;

    state_t                                state_reg, state_next;

    logic [gcsa_pkg::STEP_W-1:0]           step_reg, step_next;
    logic [gcsa_pkg::FILT_W-1:0]           filter_reg, filter_next;

    logic [gcsa_pkg::OP_W-1:0]             op_reg, op_next;
    logic [gcsa_pkg::COORD_W-1:0]          x_reg, x_next;
    logic [gcsa_pkg::COORD_W-1:0]          y_reg, y_next;
    logic signed [gcsa_pkg::STR_W-1:0]     str_reg, str_next;
    logic [gcsa_pkg::COORD_W-1:0]          qx_reg, qx_next;
    logic [gcsa_pkg::COORD_W-1:0]          qy_reg, qy_next;

    logic [gcsa_pkg::CNT_W-1:0]            used_reg, used_next;
    logic [gcsa_pkg::IDX_W-1:0]            cur_reg, cur_next;
    logic                                  open_reg, open_next;

    logic [gcsa_pkg::IDX_W-1:0]            target_reg, target_next;
    gcsa_pkg::cell_t                       ent_reg, ent_next;
    logic [gcsa_pkg::CNT_W-1:0]            scan_reg, scan_next;
    logic                                  chk_reg, chk_next;

    logic [gcsa_pkg::COORD_W-1:0]          res_x_reg, res_x_next;
    logic [gcsa_pkg::COORD_W-1:0]          res_y_reg, res_y_next;
    logic [gcsa_pkg::MEAN_W-1:0]           res_mean_reg, res_mean_next;
    logic                                  res_valid_reg, res_valid_next;
    logic                                  res_drop_reg, res_drop_next;

    logic                                  out_valid_reg, out_valid_next;
    logic [gcsa_pkg::COORD_W-1:0]          out_x_reg, out_x_next;
    logic [gcsa_pkg::COORD_W-1:0]          out_y_reg, out_y_next;
    logic [gcsa_pkg::MEAN_W-1:0]           out_mean_reg, out_mean_next;
    logic                                  out_cvalid_reg, out_cvalid_next;
    logic [gcsa_pkg::CNT_W-1:0]            out_used_reg, out_used_next;
    logic                                  out_drop_reg, out_drop_next;

    logic                                  ram_we;
    logic [gcsa_pkg::IDX_W-1:0]            ram_waddr;
    gcsa_pkg::cell_t                       ram_wdata;
    logic                                  ram_re;
    logic [gcsa_pkg::IDX_W-1:0]            ram_raddr;
    logic [gcsa_pkg::CELL_W-1:0]           ram_rdata_raw;
    gcsa_pkg::cell_t                       ram_rdata;

    gcsa_pkg::div_req_t                    div_req;
    gcsa_pkg::div_rsp_t                    div_rsp;

    logic                                  in_fire;
    logic                                  filtered;
    logic                                  starts_new;
    logic                                  scan_match;
    logic [gcsa_pkg::DIVIDEND_W-1:0]       scaled_sum;
    logic [gcsa_pkg::DIVIDEND_W-1:0]       sum_mag;
    logic [gcsa_pkg::MEAN_W-1:0]           quo_low;

    assign in_fire    = in_valid && in_ready;
    assign filtered   = (filter_reg != gcsa_pkg::FILTER_ALL)
                        && (filter_reg != {1'b0, network_id});
    // A continuation with no open measurement starts a new one.
    assign starts_new = starts_measurement || !open_reg;
    assign scan_match = chk_reg && (ram_rdata.x == qx_reg) && (ram_rdata.y == qy_reg);
    assign scaled_sum = {ent_reg.sum, {gcsa_pkg::FRAC_W{1'b0}}};
    assign sum_mag    = ent_reg.sum[gcsa_pkg::SUM_W-1]
                        ? (~scaled_sum + gcsa_pkg::DIVIDEND_W'(1)) : scaled_sum;
    assign quo_low    = div_rsp.quotient[gcsa_pkg::MEAN_W-1:0];
    assign ram_rdata  = gcsa_pkg::cell_t'(ram_rdata_raw);

    gcsa_ram #(
        .WIDTH (gcsa_pkg::CELL_W),
        .DEPTH (gcsa_pkg::MAX_CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    gcsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        filter_next     = filter_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        str_next        = str_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        open_next       = open_reg;
        target_next     = target_reg;
        ent_next        = ent_reg;
        scan_next       = scan_reg;
        chk_next        = chk_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_mean_next   = res_mean_reg;
        res_valid_next  = res_valid_reg;
        res_drop_next   = res_drop_reg;
        out_valid_next  = out_valid_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_mean_next   = out_mean_reg;
        out_cvalid_next = out_cvalid_reg;
        out_used_next   = out_used_reg;
        out_drop_next   = out_drop_reg;

        ram_we          = 1'b0;
        ram_waddr       = target_reg;
        ram_wdata.x     = ent_reg.x;
        ram_wdata.y     = ent_reg.y;
        ram_wdata.sum   = ent_reg.sum
                          + {{(gcsa_pkg::SUM_W - gcsa_pkg::STR_W){str_reg[gcsa_pkg::STR_W-1]}},
                             str_reg};
        ram_wdata.cnt   = ent_reg.cnt + gcsa_pkg::SMP_W'(1);
        ram_re          = 1'b0;
        ram_raddr       = target_reg;

        div_req.start    = 1'b0;
        div_req.dividend = gcsa_pkg::DIVIDEND_W'(x_reg);
        div_req.divisor  = gcsa_pkg::DIVISOR_W'(step_reg);

        if (cfg_write)
        begin
            unique case (cfg_index)
                gcsa_pkg::REG_GRID_STEP:      step_next   = cfg_data[gcsa_pkg::STEP_W-1:0];
                gcsa_pkg::REG_NETWORK_FILTER: filter_next = cfg_data[gcsa_pkg::FILT_W-1:0];
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next        = op;
                    x_next         = pos_x;
                    y_next         = pos_y;
                    str_next       = strength;
                    res_x_next     = '0;
                    res_y_next     = '0;
                    res_mean_next  = '0;
                    res_valid_next = 1'b0;
                    res_drop_next  = 1'b0;
                    state_next     = S_FINISH;
                    unique case (op)
                        gcsa_pkg::OP_ADD:
                        begin
                            if (filtered)
                            begin
                                res_drop_next = 1'b1;
                                if (starts_new)
                                begin
                                    open_next = 1'b0;
                                end
                            end
                            else if (!starts_new)
                            begin
                                target_next = cur_reg;
                                state_next  = S_FETCH;
                            end
                            else if (step_reg > gcsa_pkg::STEP_W'(1))
                            begin
                                state_next = S_QX;
                            end
                            else
                            begin
                                qx_next    = pos_x;
                                qy_next    = pos_y;
                                state_next = S_NEW;
                            end
                        end
                        gcsa_pkg::OP_READ:
                        begin
                            if (gcsa_pkg::CNT_W'(cell_index) < used_reg)
                            begin
                                target_next = gcsa_pkg::IDX_W'(cell_index);
                                state_next  = S_FETCH;
                            end
                        end
                        gcsa_pkg::OP_CLEAR:
                        begin
                            used_next = '0;
                            cur_next  = '0;
                            open_next = 1'b0;
                        end
                        default:
                        begin
                            // The unused code changes nothing.
                        end
                    endcase
                end
            end

            S_QX:
            begin
                div_req.start = 1'b1;
                state_next    = S_QX_WAIT;
            end

            S_QX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    qx_next    = x_reg - div_rsp.remainder[gcsa_pkg::COORD_W-1:0];
                    state_next = S_QY;
                end
            end

            S_QY:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = gcsa_pkg::DIVIDEND_W'(y_reg);
                state_next       = S_QY_WAIT;
            end

            S_QY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    qy_next    = y_reg - div_rsp.remainder[gcsa_pkg::COORD_W-1:0];
                    scan_next  = '0;
                    chk_next   = 1'b0;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                // Reads are issued one per cycle; the data of the previous
                // address is compared while the next one is requested.
                if (scan_match)
                begin
                    target_next = gcsa_pkg::IDX_W'(scan_reg - gcsa_pkg::CNT_W'(1));
                    ent_next    = ram_rdata;
                    state_next  = S_UPDATE;
                end
                else if (scan_reg >= used_reg)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = gcsa_pkg::IDX_W'(scan_reg);
                    scan_next = scan_reg + gcsa_pkg::CNT_W'(1);
                    chk_next  = 1'b1;
                end
            end

            S_NEW:
            begin
                if (used_reg == gcsa_pkg::CNT_W'(gcsa_pkg::MAX_CELLS))
                begin
                    res_drop_next = 1'b1;
                    open_next     = 1'b0;
                    state_next    = S_FINISH;
                end
                else
                begin
                    target_next  = gcsa_pkg::IDX_W'(used_reg);
                    ent_next.x   = qx_reg;
                    ent_next.y   = qy_reg;
                    ent_next.sum = '0;
                    ent_next.cnt = '0;
                    used_next    = used_reg + gcsa_pkg::CNT_W'(1);
                    state_next   = S_UPDATE;
                end
            end

            S_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                ent_next = ram_rdata;
                if (op_reg == gcsa_pkg::OP_ADD)
                begin
                    state_next = S_UPDATE;
                end
                else if (ram_rdata.cnt != '0)
                begin
                    state_next = S_MDIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_UPDATE:
            begin
                cur_next  = target_reg;
                open_next = 1'b1;
                // A saturated count leaves the cell as it is.
                if (ent_reg.cnt == '1)
                begin
                    res_drop_next = 1'b1;
                end
                else
                begin
                    ram_we = 1'b1;
                end
                state_next = S_FINISH;
            end

            S_MDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_mag;
                div_req.divisor  = ent_reg.cnt;
                state_next       = S_MDIV_WAIT;
            end

            S_MDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_x_next     = ent_reg.x;
                    res_y_next     = ent_reg.y;
                    res_valid_next = 1'b1;
                    res_mean_next  = ent_reg.sum[gcsa_pkg::SUM_W-1]
                                     ? (~quo_low + gcsa_pkg::MEAN_W'(1)) : quo_low;
                    state_next     = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = res_x_reg;
                    out_y_next      = res_y_reg;
                    out_mean_next   = res_mean_reg;
                    out_cvalid_next = res_valid_reg;
                    out_used_next   = used_reg;
                    out_drop_next   = res_drop_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= gcsa_pkg::STEP_W'(1);
            filter_reg     <= gcsa_pkg::FILTER_ALL;
            op_reg         <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            str_reg        <= '0;
            qx_reg         <= '0;
            qy_reg         <= '0;
            used_reg       <= '0;
            cur_reg        <= '0;
            open_reg       <= 1'b0;
            target_reg     <= '0;
            ent_reg        <= '0;
            scan_reg       <= '0;
            chk_reg        <= 1'b0;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_mean_reg   <= '0;
            res_valid_reg  <= 1'b0;
            res_drop_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_mean_reg   <= '0;
            out_cvalid_reg <= 1'b0;
            out_used_reg   <= '0;
            out_drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            filter_reg     <= filter_next;
            op_reg         <= op_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            str_reg        <= str_next;
            qx_reg         <= qx_next;
            qy_reg         <= qy_next;
            used_reg       <= used_next;
            cur_reg        <= cur_next;
            open_reg       <= open_next;
            target_reg     <= target_next;
            ent_reg        <= ent_next;
            scan_reg       <= scan_next;
            chk_reg        <= chk_next;
            res_x_reg      <= res_x_next;
            res_y_reg      <= res_y_next;
            res_mean_reg   <= res_mean_next;
            res_valid_reg  <= res_valid_next;
            res_drop_reg   <= res_drop_next;
            out_valid_reg  <= out_valid_next;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_mean_reg   <= out_mean_next;
            out_cvalid_reg <= out_cvalid_next;
            out_used_reg   <= out_used_next;
            out_drop_reg   <= out_drop_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign cell_x        = out_x_reg;
    assign cell_y        = out_y_reg;
    assign mean_strength = out_mean_reg;
    assign cell_valid    = out_cvalid_reg;
    assign cells_used    = out_used_reg;
    assign dropped       = out_drop_reg;

    // The cell count never passes the table size.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= gcsa_pkg::CNT_W'(gcsa_pkg::MAX_CELLS))
        else $error("cell count exceeds table size");

    // An open measurement always points at a cell that exists.
    a_open_cell: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (gcsa_pkg::CNT_W'(cur_reg) < used_reg))
        else $error("open measurement points past the used cells");

    // The RAM is written and read only inside the used part of the table.
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (gcsa_pkg::CNT_W'(ram_waddr) < used_reg))
        else $error("cell write outside the used cells");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (gcsa_pkg::CNT_W'(ram_raddr) < used_reg))
        else $error("cell read outside the used cells");

    // One request at a time: after an accept the input side closes.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("second request accepted while one is in progress");

endmodule

// ===== bench/grid_cell_sample_averager_tb.sv =====
// ----------------------------------------------------------------------------
// Grid cell sample averager testbench
// Drives add, read, clear and unused requests under several grid steps and
// network filters, predicts every response with a behavioral copy of the cell
// table, and compares each response field by field. Covers table overflow and
// merges against a full table, with random stalls on both channels.
// ----------------------------------------------------------------------------
module grid_cell_sample_averager_tb;

    localparam logic [gcsa_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                        CYCLE_LIMIT = 10000000;
    localparam int                        COUNT_MAX   = 65535;

    typedef struct packed {
        logic [gcsa_pkg::OP_W-1:0]         op;
        logic [gcsa_pkg::COORD_W-1:0]      pos_x;
        logic [gcsa_pkg::COORD_W-1:0]      pos_y;
        logic [gcsa_pkg::NID_W-1:0]        network_id;
        logic signed [gcsa_pkg::STR_W-1:0] strength;
        logic                              starts;
        logic [gcsa_pkg::SEL_W-1:0]        cell_index;
    } request_t;

    typedef struct packed {
        logic [gcsa_pkg::COORD_W-1:0] cell_x;
        logic [gcsa_pkg::COORD_W-1:0] cell_y;
        logic [gcsa_pkg::MEAN_W-1:0]  mean;
        logic                         valid;
        logic [gcsa_pkg::CNT_W-1:0]   used;
        logic                         dropped;
    } cell_result_t;

    class cell_average_scoreboard;
        logic [gcsa_pkg::COORD_W-1:0] coord_x [gcsa_pkg::MAX_CELLS];
        logic [gcsa_pkg::COORD_W-1:0] coord_y [gcsa_pkg::MAX_CELLS];
        int                           sample_sum [gcsa_pkg::MAX_CELLS];
        int                           sample_count [gcsa_pkg::MAX_CELLS];
        int                           cells_in_use;
        int                           open_cell;
        bit                           measurement_open;
        int                           grid_step;
        int                           keep_network;
        cell_result_t                 pending_results [$];
        int                           errors;
        int                           results_seen;

        function new();
            cells_in_use     = 0;
            open_cell        = 0;
            measurement_open = 0;
            grid_step        = 1;
            keep_network     = -1;
            errors           = 0;
            results_seen     = 0;
        endfunction

        function void set_register(logic [gcsa_pkg::REG_IDX_W-1:0] index,
                                   logic [gcsa_pkg::CFG_W-1:0] data);
            if (index == gcsa_pkg::REG_GRID_STEP)
                grid_step = int'(data[gcsa_pkg::STEP_W-1:0]);
            else if (index == gcsa_pkg::REG_NETWORK_FILTER)
                keep_network = int'($signed(data));
        endfunction

        function logic [gcsa_pkg::COORD_W-1:0] quantize(logic [gcsa_pkg::COORD_W-1:0] v);
            if (grid_step > 1)
                return (v / grid_step) * grid_step;
            return v;
        endfunction

        // Returns 1 when the sample is discarded.
        function bit add_sample(request_t r);
            logic [gcsa_pkg::COORD_W-1:0] qx;
            logic [gcsa_pkg::COORD_W-1:0] qy;
            int                           level;
            int                           target;
            int                           i;
            bit                           opens;
            bit                           found;
            qx     = quantize(r.pos_x);
            qy     = quantize(r.pos_y);
            level  = int'($signed(r.strength));
            opens  = r.starts || !measurement_open;
            found  = 0;
            target = 0;
            if (keep_network != -1 && int'(r.network_id) != keep_network)
            begin
                if (opens)
                    measurement_open = 0;
                return 1;
            end
            if (!opens)
            begin
                target = open_cell;
                found  = 1;
            end
            else if (grid_step > 1)
            begin
                for (i = 0; i < cells_in_use && !found; i++)
                begin
                    if (coord_x[i] == qx && coord_y[i] == qy)
                    begin
                        target = i;
                        found  = 1;
                    end
                end
            end
            if (!found)
            begin
                if (cells_in_use >= gcsa_pkg::MAX_CELLS)
                begin
                    measurement_open = 0;
                    return 1;
                end
                target               = cells_in_use;
                coord_x[target]      = qx;
                coord_y[target]      = qy;
                sample_sum[target]   = 0;
                sample_count[target] = 0;
                cells_in_use++;
            end
            open_cell        = target;
            measurement_open = 1;
            if (sample_count[target] == COUNT_MAX)
                return 1;
            sample_sum[target] += level;
            sample_count[target]++;
            return 0;
        endfunction

        function void note_request(request_t r);
            cell_result_t res;
            int           quotient;
            res = '0;
            case (r.op)
                gcsa_pkg::OP_ADD: res.dropped = add_sample(r);
                gcsa_pkg::OP_READ:
                begin
                    if (int'(r.cell_index) < cells_in_use && sample_count[r.cell_index] != 0)
                    begin
                        quotient   = (sample_sum[r.cell_index] * 16) / sample_count[r.cell_index];
                        res.cell_x = coord_x[r.cell_index];
                        res.cell_y = coord_y[r.cell_index];
                        res.mean   = quotient[gcsa_pkg::MEAN_W-1:0];
                        res.valid  = 1'b1;
                    end
                end
                gcsa_pkg::OP_CLEAR:
                begin
                    cells_in_use     = 0;
                    open_cell        = 0;
                    measurement_open = 0;
                end
                default: ;
            endcase
            res.used = gcsa_pkg::CNT_W'(cells_in_use);
            pending_results = {pending_results, res};
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            errors++;
            $display("response %0d: %s is %0h, expected %0h", results_seen, what, got, want);
        endtask

        task check_result(input cell_result_t seen);
            cell_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("response without request", 1, 0);
                return;
            end
            want = pending_results.pop_front();
            if (seen.cell_x !== want.cell_x)
                report_mismatch("cell_x", seen.cell_x, want.cell_x);
            if (seen.cell_y !== want.cell_y)
                report_mismatch("cell_y", seen.cell_y, want.cell_y);
            if (seen.mean !== want.mean)
                report_mismatch("mean_strength", seen.mean, want.mean);
            if (seen.valid !== want.valid)
                report_mismatch("cell_valid", seen.valid, want.valid);
            if (seen.used !== want.used)
                report_mismatch("cells_used", seen.used, want.used);
            if (seen.dropped !== want.dropped)
                report_mismatch("dropped", seen.dropped, want.dropped);
        endtask
    endclass

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    request_t                           in_req    = '0;
    logic                               out_ready = 1'b0;
    logic                               cfg_write = 1'b0;
    logic [gcsa_pkg::REG_IDX_W-1:0]     cfg_index = gcsa_pkg::REG_GRID_STEP;
    logic [gcsa_pkg::CFG_W-1:0]         cfg_data  = '0;

    logic                               in_ready;
    logic                               out_valid;
    logic [gcsa_pkg::COORD_W-1:0]       cell_x;
    logic [gcsa_pkg::COORD_W-1:0]       cell_y;
    logic signed [gcsa_pkg::MEAN_W-1:0] mean_strength;
    logic                               cell_valid;
    logic [gcsa_pkg::CNT_W-1:0]         cells_used;
    logic                               dropped;
    cell_result_t                       seen_result;

    cell_average_scoreboard scoreboard = new();
    bit                     idle_enabled = 1;
    int                     stall_left   = 0;
    int                     cycle_count  = 0;

    assign seen_result = {cell_x, cell_y, mean_strength, cell_valid, cells_used, dropped};

    grid_cell_sample_averager uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (in_req.op),
        .pos_x              (in_req.pos_x),
        .pos_y              (in_req.pos_y),
        .network_id         (in_req.network_id),
        .strength           (in_req.strength),
        .starts_measurement (in_req.starts),
        .cell_index         (in_req.cell_index),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .cell_x             (cell_x),
        .cell_y             (cell_y),
        .mean_strength      (mean_strength),
        .cell_valid         (cell_valid),
        .cells_used         (cells_used),
        .dropped            (dropped),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Response side: check every accepted response and stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            scoreboard.check_result(seen_result);
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_enabled && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic request_t add_request(logic [gcsa_pkg::COORD_W-1:0] x,
                                             logic [gcsa_pkg::COORD_W-1:0] y,
                                             logic [gcsa_pkg::NID_W-1:0] nid,
                                             logic signed [gcsa_pkg::STR_W-1:0] level,
                                             logic starts);
        request_t r;
        r.op         = gcsa_pkg::OP_ADD;
        r.pos_x      = x;
        r.pos_y      = y;
        r.network_id = nid;
        r.strength   = level;
        r.starts     = starts;
        r.cell_index = gcsa_pkg::SEL_W'($urandom);
        return r;
    endfunction

    function automatic request_t op_request(logic [gcsa_pkg::OP_W-1:0] code,
                                            logic [gcsa_pkg::SEL_W-1:0] index);
        request_t r;
        r            = add_request(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                                   1'($urandom));
        r.op         = code;
        r.cell_index = index;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       keep;
        int       grid;
        r    = op_request(gcsa_pkg::OP_ADD, gcsa_pkg::SEL_W'($urandom));
        pick = $urandom_range(0, 99);
        keep = scoreboard.keep_network;
        grid = scoreboard.grid_step;
        if (pick < 70)
        begin
            r.starts = ($urandom_range(0, 3) == 0);
            if (keep >= 0 && $urandom_range(0, 5) != 0)
                r.network_id = keep[gcsa_pkg::NID_W-1:0];
            // Keep most positions in a few cells so that merging happens.
            if (grid > 1 && $urandom_range(0, 4) != 0)
            begin
                r.pos_x = 16'($urandom_range(0, 3) * grid + $urandom_range(0, grid - 1));
                r.pos_y = 16'($urandom_range(0, 3) * grid + $urandom_range(0, grid - 1));
            end
        end
        else if (pick < 92)
        begin
            r.op = gcsa_pkg::OP_READ;
            if ($urandom_range(0, 3) != 0)
                r.cell_index = gcsa_pkg::SEL_W'($urandom_range(0, scoreboard.cells_in_use + 1));
        end
        else if (pick < 98)
        begin
            r.op = gcsa_pkg::OP_CLEAR;
        end
        else
        begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic send_request(input request_t r);
        if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scoreboard.note_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (scoreboard.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [gcsa_pkg::STEP_W-1:0] grid,
                             input logic [gcsa_pkg::FILT_W-1:0] filter);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= gcsa_pkg::REG_GRID_STEP;
        cfg_data  <= gcsa_pkg::CFG_W'(grid);
        @(posedge clk);
        scoreboard.set_register(gcsa_pkg::REG_GRID_STEP, gcsa_pkg::CFG_W'(grid));
        cfg_index <= gcsa_pkg::REG_NETWORK_FILTER;
        cfg_data  <= filter;
        @(posedge clk);
        scoreboard.set_register(gcsa_pkg::REG_NETWORK_FILTER, filter);
        cfg_write <= 1'b0;
    endtask

    task automatic random_phase(input logic [gcsa_pkg::STEP_W-1:0] grid,
                                input logic [gcsa_pkg::FILT_W-1:0] filter,
                                input int count);
        configure(grid, filter);
        repeat (count)
            send_request(random_request());
    endtask

    // Fill the table past its capacity, then try merges against the full table.
    task automatic overflow_phase();
        request_t r;
        int       extra;
        int       pick;
        extra = 0;
        configure(8'd1, gcsa_pkg::FILTER_ALL);
        send_request(op_request(gcsa_pkg::OP_CLEAR, '0));
        while (extra < 40)
        begin
            r        = random_request();
            r.op     = ($urandom_range(0, 19) == 0) ? gcsa_pkg::OP_READ : gcsa_pkg::OP_ADD;
            r.starts = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 1))
            begin
                r.pos_x[1:0] = 2'b00;
                r.pos_y[1:0] = 2'b00;
            end
            send_request(r);
            if (scoreboard.cells_in_use == gcsa_pkg::MAX_CELLS)
                extra++;
        end
        configure(8'd4, gcsa_pkg::FILTER_ALL);
        repeat (16)
        begin
            r        = random_request();
            r.op     = gcsa_pkg::OP_ADD;
            r.starts = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
            begin
                pick    = $urandom_range(0, gcsa_pkg::MAX_CELLS - 1);
                r.pos_x = scoreboard.coord_x[pick] + 16'($urandom_range(0, 3));
                r.pos_y = scoreboard.coord_y[pick] + 16'($urandom_range(0, 3));
            end
            send_request(r);
        end
        send_request(op_request(gcsa_pkg::OP_READ, gcsa_pkg::SEL_W'(gcsa_pkg::MAX_CELLS - 1)));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings; continuation without an open measurement, extremes, reads.
        configure(8'd1, gcsa_pkg::FILTER_ALL);
        send_request(op_request(gcsa_pkg::OP_READ, '0));
        send_request(op_request(OP_UNUSED, '1));
        send_request(add_request(16'h0000, 16'h0000, 8'd0, -8'sd128, 1'b0));
        send_request(add_request(16'hFFFF, 16'hFFFF, 8'd255, 8'sd127, 1'b0));
        send_request(add_request(16'd1234, 16'd4321, 8'd17, -8'sd1, 1'b1));
        send_request(add_request(16'd1, 16'd2, 8'd3, -8'sd127, 1'b0));
        send_request(op_request(gcsa_pkg::OP_READ, 10'd0));
        send_request(op_request(gcsa_pkg::OP_READ, 10'd1));
        send_request(op_request(gcsa_pkg::OP_READ, 10'd2));
        send_request(op_request(gcsa_pkg::OP_READ, 10'd1023));
        send_request(op_request(gcsa_pkg::OP_CLEAR, '0));
        send_request(op_request(gcsa_pkg::OP_READ, 10'd0));

        // Filter on network 5: a filtered start closes the open measurement.
        configure(8'd0, 9'd5);
        send_request(add_request(16'd5, 16'd5, 8'd5, 8'sd10, 1'b1));
        send_request(add_request(16'd6, 16'd6, 8'd6, 8'sd20, 1'b1));
        send_request(add_request(16'd7, 16'd7, 8'd5, 8'sd30, 1'b0));
        send_request(add_request(16'd8, 16'd8, 8'd7, 8'sd40, 1'b0));
        send_request(add_request(16'd9, 16'd9, 8'd5, -8'sd5, 1'b0));
        send_request(op_request(gcsa_pkg::OP_READ, 10'd1));

        // Largest step: samples merge by quantized position.
        configure(8'd255, gcsa_pkg::FILTER_ALL);
        send_request(add_request(16'd300, 16'd10, 8'd9, 8'sd3, 1'b1));
        send_request(add_request(16'd509, 16'd100, 8'd9, -8'sd4, 1'b1));
        send_request(add_request(16'hFFFF, 16'hFFFF, 8'd9, 8'sd1, 1'b1));
        send_request(op_request(gcsa_pkg::OP_READ, 10'd0));

        // A negative filter other than keep-all matches nothing.
        configure(8'd2, 9'h1FE);
        send_request(add_request(16'd4, 16'd4, 8'd254, 8'sd1, 1'b1));
        send_request(add_request(16'd4, 16'd4, 8'd255, 8'sd1, 1'b0));

        random_phase(8'd1, gcsa_pkg::FILTER_ALL, 100);
        random_phase(8'd0, 9'd255, 60);
        random_phase(8'd2, gcsa_pkg::FILTER_ALL, 80);
        random_phase(8'd16, 9'd0, 60);
        random_phase(8'd255, gcsa_pkg::FILTER_ALL, 40);
        random_phase(8'd7, 9'h100, 20);
        random_phase(8'd128, 9'd77, 50);
        overflow_phase();

        idle_enabled = 0;
        random_phase(8'd3, gcsa_pkg::FILTER_ALL, 130);

        drain();
        repeat (200) @(posedge clk);
        if (scoreboard.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
